FILE: rtl/mf3_pkg.sv
package mf3_pkg;

    // Register map (byte address = 4 * index)
    localparam int REG_IMAGE_WIDTH  = 0;
    localparam int REG_IMAGE_HEIGHT = 1;

    // Configuration field widths and limits
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam int MIN_DIM         = 3;
    localparam int MAX_HEIGHT      = 4096;
    localparam int RESET_WIDTH     = 512;
    localparam int RESET_HEIGHT    = 512;

    // Output row counter: rows 0 .. MAX_HEIGHT-1
    localparam int ROW_W = 12;

    // Bus widths
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Input beat kinds (carried on s_tuser)
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

endpackage

FILE: rtl/median_filter_3x3_core.sv
// 3x3 median filter core, grayscale raster stream of PIXEL_BITS-bit pixels (8 by default).
// An accepted beat passes s1, then the output register that drives m_tvalid; on the
//   stream the result for a pixel appears image_width+1 input beats after that pixel.
// Throughput: one input beat per cycle unless the output stalls, set by the line store
//   read/write and one-pass 19-exchange median network from s1 to the output register.
// Reset: aresetn, synchronous, active low; clears counters, window and handshakes.
//   Line stores are not cleared; their unwritten entries never reach a result.
module median_filter_3x3_core #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF,
    localparam int TDATA_W   = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [TDATA_W-1:0]              s_tdata,   // [PIXEL_BITS-1:0] pixel_in
    input  logic                            s_tuser,   // [0] op (0 pixel, 1 flush)

    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [TDATA_W-1:0]              m_tdata,   // [PIXEL_BITS-1:0] pixel_out
    output logic                            m_tlast,   // frame_end

    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mf3_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mf3_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mf3_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import mf3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > CFG_WIDTH_BITS) ? COL_W + 1 : CFG_WIDTH_BITS;
    localparam int NET_N = 19;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef logic [8:0][PIXEL_BITS-1:0] nine_t;

    // Exchange network for the median of nine; after it, slot 4 holds the median.
    localparam int NET_A [NET_N] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
    localparam int NET_B [NET_N] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

    function automatic pix_t median9(input nine_t v);
        nine_t p;
        pix_t  t;
        p = v;
        for (int i = 0; i < NET_N; i++) begin
            if (p[NET_A[i]] > p[NET_B[i]]) begin
                t           = p[NET_A[i]];
                p[NET_A[i]] = p[NET_B[i]];
                p[NET_B[i]] = t;
            end
        end
        return p[4];
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CFG_WIDTH_BITS-1:0]  image_width_reg;
    logic [CFG_HEIGHT_BITS-1:0] image_height_reg;
    logic [CFG_WIDTH_BITS-1:0]  width_clamped;
    logic [CFG_HEIGHT_BITS-1:0] height_clamped;
    logic                       cfg_write;
    logic                       cfg_is_height;

    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite && pready;
    // word decode: paddr[2] selects the register
    assign cfg_is_height = paddr[2];

    always_comb begin
        priority if (32'(pwdata[CFG_WIDTH_BITS-1:0]) < 32'(MIN_DIM)) begin
            width_clamped = CFG_WIDTH_BITS'(MIN_DIM);
        end else if (32'(pwdata[CFG_WIDTH_BITS-1:0]) > 32'(MAX_WIDTH)) begin
            width_clamped = CFG_WIDTH_BITS'(MAX_WIDTH);
        end else begin
            width_clamped = pwdata[CFG_WIDTH_BITS-1:0];
        end
        priority if (32'(pwdata[CFG_HEIGHT_BITS-1:0]) < 32'(MIN_DIM)) begin
            height_clamped = CFG_HEIGHT_BITS'(MIN_DIM);
        end else if (32'(pwdata[CFG_HEIGHT_BITS-1:0]) > 32'(MAX_HEIGHT)) begin
            height_clamped = CFG_HEIGHT_BITS'(MAX_HEIGHT);
        end else begin
            height_clamped = pwdata[CFG_HEIGHT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= CFG_WIDTH_BITS'(RESET_WIDTH);
            image_height_reg <= CFG_HEIGHT_BITS'(RESET_HEIGHT);
        end else if (cfg_write) begin
            if (cfg_is_height == 1'(REG_IMAGE_HEIGHT)) begin
                image_height_reg <= height_clamped;
            end else begin
                image_width_reg <= width_clamped;
            end
        end
    end

    assign prdata = (cfg_is_height == 1'(REG_IMAGE_HEIGHT)) ? APB_DATA_W'(image_height_reg)
                                                             : APB_DATA_W'(image_width_reg);

    // ---------------------------------------------------------------
    // Handshake and stage control
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_emit_reg;
    logic s1_border_reg;
    logic s1_last_reg;
    pix_t s1_val_reg;
    logic [COL_W-1:0] s1_col_reg;

    logic m_valid_reg;
    pix_t m_pixel_reg;
    logic m_last_reg;

    logic out_free;
    logic s1_go;
    logic accept;

    assign out_free = !m_valid_reg || m_tready;
    // a beat that yields no result leaves s1 without needing the output register
    assign s1_go    = s1_valid_reg && (!s1_emit_reg || out_free);
    assign s_tready = !s1_valid_reg || s1_go;
    assign accept   = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Position counters: input column, saturated input row (0, 1, 2+),
    // output column and output row of the next result.
    // ---------------------------------------------------------------
    logic [COL_W-1:0] in_col_reg,  in_col_next;
    logic [1:0]       in_row_reg,  in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic [CFG_WIDTH_BITS-1:0]  width_m1;
    logic [CFG_HEIGHT_BITS-1:0] height_m1;
    logic in_col_end, out_col_end, out_row_first, out_row_end;
    logic emit, border, last;
    pix_t in_val;

    assign width_m1      = image_width_reg - CFG_WIDTH_BITS'(1);
    assign height_m1     = image_height_reg - CFG_HEIGHT_BITS'(1);
    assign in_col_end    = CMP_W'(in_col_reg) == CMP_W'(width_m1);
    assign out_col_end   = CMP_W'(out_col_reg) == CMP_W'(width_m1);
    assign out_row_first = out_row_reg == '0;
    assign out_row_end   = CFG_HEIGHT_BITS'(out_row_reg) == height_m1;

    // results start at row 1, column 1 of the input: image_width+1 beats of lag
    assign emit   = (in_row_reg == 2'd2) || (in_row_reg == 2'd1 && in_col_reg != '0);
    assign border = out_row_first || out_row_end || (out_col_reg == '0) || out_col_end;
    assign last   = out_row_end && out_col_end;
    // a flush beat enters the pipe as a zero pixel
    assign in_val = (s_tuser == OP_FLUSH) ? '0 : s_tdata[PIXEL_BITS-1:0];

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept) begin
            if (in_col_end) begin
                in_col_next = '0;
                if (in_row_reg != 2'd2) begin
                    in_row_next = in_row_reg + 2'd1;
                end
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit) begin
                if (out_col_end) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
            // frame done: the next beat starts a new frame
            if (emit && last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_write) begin
            // a register write restarts the frame
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage s1: beat fields plus registered line store reads
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_emit_reg   <= emit;
            s1_border_reg <= border;
            s1_last_reg   <= last;
            s1_val_reg    <= in_val;
            s1_col_reg    <= in_col_reg;
        end
    end

    // Line stores: upper holds row r-2, middle row r-1. Read at accept,
    // written back when the beat leaves s1. The next beat reads another
    // column, except right after a frame end where both sit at column 0;
    // that read only feeds rows above the new frame, which never reach
    // a result.
    pix_t upper_mem  [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];
    pix_t rd_upper_reg;
    pix_t rd_middle_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_upper_reg  <= upper_mem[in_col_reg];
            rd_middle_reg <= middle_mem[in_col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            upper_mem[s1_col_reg]  <= rd_middle_reg;
            middle_mem[s1_col_reg] <= s1_val_reg;
        end
    end

    // ---------------------------------------------------------------
    // Window: slots 0..2 column c-1 (top, mid, bottom), 3..5 column c-2
    // ---------------------------------------------------------------
    pix_t  win_reg [6];
    nine_t nine;
    pix_t  median;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_go) begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= rd_upper_reg;
            win_reg[1] <= rd_middle_reg;
            win_reg[2] <= s1_val_reg;
        end
    end

    always_comb begin
        nine[0] = rd_upper_reg;
        nine[1] = rd_middle_reg;
        nine[2] = s1_val_reg;
        for (int i = 0; i < 6; i++) begin
            nine[3 + i] = win_reg[i];
        end
        median = median9(nine);
    end

    // ---------------------------------------------------------------
    // Output register; border pixels take the window center as is
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_go && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_go && s1_emit_reg) begin
            m_pixel_reg <= s1_border_reg ? win_reg[1] : median;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_pixel_reg);
    assign m_tlast  = m_last_reg;

endmodule
